// ===== design/enf_pkg.sv =====
// ----------------------------------------------------------------------------
// enf_pkg: shared constants for the event neighbour filter
// Field widths, stream packing, register indexes, reset values and default array size.
// ----------------------------------------------------------------------------
`default_nettype none

package enf_pkg;

  // Event field widths
  localparam int unsigned COORD_W = 8;
  localparam int unsigned STAMP_W = 31;

  // Stream packing: col, row, stamp in tdata, padded to whole bytes
  localparam int unsigned TDATA_W = 48;
  localparam int unsigned COL_LSB = 0;
  localparam int unsigned ROW_LSB = COORD_W;
  localparam int unsigned STAMP_LSB = 2 * COORD_W;

  // Configuration port
  localparam int unsigned CFG_IDX_W = 2;
  localparam int unsigned CFG_DATA_W = 31;
  localparam int unsigned SIZE_REG_W = 9;
  // Width that holds any sensor size up to the largest supported array
  localparam int unsigned SIZE_W = 11;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_WINDOW        = 2'd0,
    REG_SENSOR_WIDTH  = 2'd1,
    REG_SENSOR_HEIGHT = 2'd2,
    REG_UNUSED        = 2'd3
  } cfg_reg_t;

  // Register reset values
  localparam logic [STAMP_W-1:0]    WINDOW_RST        = 31'd5000;
  localparam logic [SIZE_REG_W-1:0] SENSOR_WIDTH_RST  = 9'd240;
  localparam logic [SIZE_REG_W-1:0] SENSOR_HEIGHT_RST = 9'd180;

  // Default pixel array size
  localparam int unsigned MAX_WIDTH_DEF  = 256;
  localparam int unsigned MAX_HEIGHT_DEF = 256;

endpackage

`default_nettype wire

// ===== design/event_neighbour_filter.sv =====
// ----------------------------------------------------------------------------
// event_neighbour_filter: 3x3 background-activity filter for event streams
// Keeps the last timestamp of each pixel and passes an event when a valid
// neighbour fired within the configured window.
// ----------------------------------------------------------------------------
// After reset the block sweeps the timestamp memory once to clear the valid
// flags of all MAX_WIDTH*MAX_HEIGHT words (65536 with the defaults), during
// which s_tready stays low; configuration writes are taken at any time. The
// store is one single-port-read, single-port-write memory of {valid, stamp}
// words, and the neighbourhood is read one pixel per cycle, so an event goes
// through accept, nine read slots and write-back. A repeat of the previous
// event skips the reads; an off-sensor event ends at accept. The result sits
// in an output register, so the next event is accepted while it waits.
`default_nettype none

module event_neighbour_filter
  import enf_pkg::*;
#(
  parameter int unsigned MAX_WIDTH  = MAX_WIDTH_DEF,
  parameter int unsigned MAX_HEIGHT = MAX_HEIGHT_DEF
) (
  input  wire logic                  clk,
  input  wire logic                  rst,
  // Input events
  input  wire logic                  s_tvalid,
  output logic                       s_tready,
  input  wire logic [TDATA_W-1:0]    s_tdata,   // col[7:0], row[15:8], stamp[46:16]
  input  wire logic                  s_tuser,   // polarity
  // Passed events
  output logic                       m_tvalid,
  input  wire logic                  m_tready,
  output logic [TDATA_W-1:0]         m_tdata,   // out_col[7:0], out_row[15:8],
                                                // out_stamp[46:16]
  output logic                       m_tuser,   // out_polarity
  // Configuration
  input  wire logic                  cfg_we,
  input  wire logic [CFG_IDX_W-1:0]  cfg_index,
  input  wire logic [CFG_DATA_W-1:0] cfg_data
);

  localparam int unsigned PIXELS = MAX_WIDTH * MAX_HEIGHT;
  localparam int unsigned AW     = $clog2(PIXELS);
  localparam int unsigned MW     = STAMP_W + 1;

  typedef enum logic [3:0] {
    S_CLEAR = 4'b0001,
    S_IDLE  = 4'b0010,
    S_READ  = 4'b0100,
    S_WRITE = 4'b1000
  } state_t;

  state_t state, state_next;

  // Configuration registers
  logic [STAMP_W-1:0]    window;
  logic [SIZE_REG_W-1:0] sensor_width;
  logic [SIZE_REG_W-1:0] sensor_height;

  always_ff @(posedge clk) begin
    if (rst) begin
      window        <= WINDOW_RST;
      sensor_width  <= SENSOR_WIDTH_RST;
      sensor_height <= SENSOR_HEIGHT_RST;
    end else if (cfg_we) begin
      case (cfg_reg_t'(cfg_index))
        REG_WINDOW:        window        <= cfg_data[STAMP_W-1:0];
        REG_SENSOR_WIDTH:  sensor_width  <= cfg_data[SIZE_REG_W-1:0];
        REG_SENSOR_HEIGHT: sensor_height <= cfg_data[SIZE_REG_W-1:0];
        default: ;
      endcase
    end
  end

  // Effective sensor size, clipped to the array
  logic [SIZE_W-1:0] w_eff, h_eff;
  assign w_eff = (SIZE_W'(sensor_width) > SIZE_W'(MAX_WIDTH)) ?
                 SIZE_W'(MAX_WIDTH) : SIZE_W'(sensor_width);
  assign h_eff = (SIZE_W'(sensor_height) > SIZE_W'(MAX_HEIGHT)) ?
                 SIZE_W'(MAX_HEIGHT) : SIZE_W'(sensor_height);

  // Input unpacking
  logic [COORD_W-1:0] in_col, in_row;
  logic [STAMP_W-1:0] in_stamp;
  logic               in_acc, in_range, in_repeat;

  assign in_col   = s_tdata[COL_LSB +: COORD_W];
  assign in_row   = s_tdata[ROW_LSB +: COORD_W];
  assign in_stamp = s_tdata[STAMP_LSB +: STAMP_W];
  assign in_acc   = s_tvalid && s_tready;
  assign in_range = (SIZE_W'(in_col) < w_eff) && (SIZE_W'(in_row) < h_eff);

  // Current event and previous-event registers
  logic [COORD_W-1:0] cur_col, cur_row, prev_col, prev_row;
  logic [STAMP_W-1:0] cur_stamp;
  logic               cur_pol, prev_pol;

  assign in_repeat = (in_col == prev_col) && (in_row == prev_row) &&
                     (s_tuser == prev_pol);

  always_ff @(posedge clk) begin
    if (rst) begin
      prev_col <= '0;
      prev_row <= '0;
      prev_pol <= 1'b0;
    end else if (in_acc && in_range) begin
      prev_col <= in_col;
      prev_row <= in_row;
      prev_pol <= s_tuser;
    end
  end

  always_ff @(posedge clk) begin
    if (in_acc && in_range) begin
      cur_col   <= in_col;
      cur_row   <= in_row;
      cur_stamp <= in_stamp;
      cur_pol   <= s_tuser;
    end
  end

  // Neighbourhood walk: row offset ni, column offset nj, each 0..2 (offset+1)
  logic [1:0] ni, nj;
  logic       walk_last;
  assign walk_last = (ni == 2'd2) && (nj == 2'd2);

  always_ff @(posedge clk) begin
    if (in_acc) begin
      ni <= 2'd0;
      nj <= 2'd0;
    end else if (state == S_READ) begin
      if (nj == 2'd2) begin
        nj <= 2'd0;
        ni <= ni + 2'd1;
      end else begin
        nj <= nj + 2'd1;
      end
    end
  end

  // Neighbour coordinates, shifted up by one so the upper-left edge stays >= 0
  logic [COORD_W:0] nr_ext, nc_ext, nr, nc;
  logic             nb_ok;

  assign nr_ext = {1'b0, cur_row} + (COORD_W+1)'(ni);
  assign nc_ext = {1'b0, cur_col} + (COORD_W+1)'(nj);
  assign nr     = nr_ext - (COORD_W+1)'(1);
  assign nc     = nc_ext - (COORD_W+1)'(1);
  assign nb_ok  = (nr_ext != '0) && (nc_ext != '0) &&
                  (SIZE_W'(nr) < h_eff) && (SIZE_W'(nc) < w_eff) &&
                  !((ni == 2'd1) && (nj == 2'd1));

  // Memory addresses
  logic [AW-1:0] nb_addr, here_addr, clr_addr;
  assign nb_addr   = AW'(nr) * AW'(MAX_WIDTH) + AW'(nc);
  assign here_addr = AW'(cur_row) * AW'(MAX_WIDTH) + AW'(cur_col);

  // Timestamp store: {valid, stamp}, read data registered
  logic [MW-1:0] mem [PIXELS];
  logic [MW-1:0] rd_data, wr_data;
  logic [AW-1:0] wr_addr;
  logic          wr_en, rd_en;

  assign rd_en = (state == S_READ) && nb_ok;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data <= mem[nb_addr];
    end
  end

  // Marks that rd_data holds a neighbour to check this cycle
  logic rd_chk;
  always_ff @(posedge clk) begin
    if (rst) begin
      rd_chk <= 1'b0;
    end else begin
      rd_chk <= rd_en;
    end
  end

  // Age check: a valid neighbour no older than the window (or in the future)
  logic [STAMP_W:0] age;
  logic             hit, pass_acc, pass_now;

  assign age      = {1'b0, cur_stamp} - {1'b0, rd_data[STAMP_W-1:0]};
  assign hit      = rd_chk && rd_data[STAMP_W] &&
                    (age[STAMP_W] || (age[STAMP_W-1:0] <= window));
  assign pass_now = pass_acc || hit;

  // A stamp of zero passes through the own-pixel term alone
  always_ff @(posedge clk) begin
    if (in_acc) begin
      pass_acc <= !in_repeat && (in_stamp == '0);
    end else begin
      pass_acc <= pass_now;
    end
  end

  // Clearing sweep counter
  always_ff @(posedge clk) begin
    if (rst) begin
      clr_addr <= '0;
    end else if (state == S_CLEAR) begin
      clr_addr <= clr_addr + AW'(1);
    end
  end

  // Write port: clearing sweep or write-back of the event stamp
  logic out_busy, wb_go;
  assign out_busy = m_tvalid && !m_tready;
  assign wb_go    = (state == S_WRITE) && !(pass_now && out_busy);

  always_comb begin
    wr_en   = 1'b0;
    wr_addr = here_addr;
    wr_data = {1'b1, cur_stamp};
    if (state == S_CLEAR) begin
      wr_en   = 1'b1;
      wr_addr = clr_addr;
      wr_data = '0;
    end else if (wb_go) begin
      wr_en = 1'b1;
    end
  end

  // Sequencer
  always_comb begin
    state_next = state;
    case (state)
      S_CLEAR: if (clr_addr == AW'(PIXELS - 1)) state_next = S_IDLE;
      S_IDLE: begin
        if (in_acc && in_range) begin
          state_next = in_repeat ? S_WRITE : S_READ;
        end
      end
      S_READ:  if (walk_last) state_next = S_WRITE;
      S_WRITE: if (wb_go) state_next = S_IDLE;
      default: state_next = S_CLEAR;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_CLEAR;
    end else begin
      state <= state_next;
    end
  end

  assign s_tready = (state == S_IDLE);

  // Output register
  logic out_load;
  assign out_load = wb_go && pass_now;

  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (out_load) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      m_tdata <= {(TDATA_W - STAMP_W - 2*COORD_W)'(0), cur_stamp, cur_row, cur_col};
      m_tuser <= cur_pol;
    end
  end

endmodule

`default_nettype wire

// ===== design/enf_checker.sv =====
// ----------------------------------------------------------------------------
// enf_checker: port-level checks for the event neighbour filter
// Watches reset behavior, output stalls and result timing.
// ----------------------------------------------------------------------------
`default_nettype none

module enf_checker
  import enf_pkg::*;
(
  input wire logic               clk,
  input wire logic               rst,
  input wire logic               s_tvalid,
  input wire logic               s_tready,
  input wire logic               m_tvalid,
  input wire logic               m_tready,
  input wire logic [TDATA_W-1:0] m_tdata,
  input wire logic               m_tuser
);

  // The clearing sweep follows reset, so no input is taken right after it
  a_no_accept_after_rst: assert property (@(posedge clk)
    rst |=> !s_tready)
    else $error("input ready in the cycle after reset");

  // No result is pending after reset
  a_no_result_after_rst: assert property (@(posedge clk)
    rst |=> !m_tvalid)
    else $error("result valid in the cycle after reset");

  // A stalled result holds its contents
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser))
    else $error("stalled result changed");

  // A new result never appears in the cycle right after an input transaction
  a_result_latency: assert property (@(posedge clk) disable iff (rst)
    $rose(m_tvalid) |-> !$past(s_tvalid && s_tready))
    else $error("result appeared too soon after an input transaction");

endmodule

bind event_neighbour_filter enf_checker u_enf_checker (.*);

`default_nettype wire

// ===== sim/tb_event_neighbour_filter.sv =====
// ----------------------------------------------------------------------------
// tb_event_neighbour_filter: self-checking bench for the 3x3 activity filter
// Streams directed and random events through the filter under several window
// and sensor-size settings, with random gaps and stalls on both streams, and
// compares every passed event with a behavioral model of the filter.
// ----------------------------------------------------------------------------
module tb_event_neighbour_filter;
  import enf_pkg::*;

  localparam int unsigned PIXELS = MAX_WIDTH_DEF * MAX_HEIGHT_DEF;
  localparam logic [STAMP_W-1:0] STAMP_MAX = 31'h7FFF_FFFF;
  localparam int SETTLE_CYCLES = 24;

  typedef struct packed {
    logic [COORD_W-1:0] col;
    logic [COORD_W-1:0] row;
    logic [STAMP_W-1:0] stamp;
    logic               pol;
  } ev_t;

  // DUT ports
  logic                  clk = 1'b0;
  logic                  rst = 1'b1;
  logic                  s_tvalid = 1'b0;
  logic                  s_tready;
  logic [TDATA_W-1:0]    s_tdata = '0;
  logic                  s_tuser = 1'b0;
  logic                  m_tvalid;
  logic                  m_tready = 1'b0;
  logic [TDATA_W-1:0]    m_tdata;
  logic                  m_tuser;
  logic                  cfg_we = 1'b0;
  logic [CFG_IDX_W-1:0]  cfg_index = REG_WINDOW;
  logic [CFG_DATA_W-1:0] cfg_data = '0;

  // Filter model state
  logic [STAMP_W-1:0]    stamp_mem [PIXELS];
  bit                    seen_mem [PIXELS];
  logic [COORD_W-1:0]    last_col = '0;
  logic [COORD_W-1:0]    last_row = '0;
  logic                  last_pol = 1'b0;
  logic [STAMP_W-1:0]    win_reg = WINDOW_RST;
  logic [SIZE_REG_W-1:0] width_reg = SENSOR_WIDTH_RST;
  logic [SIZE_REG_W-1:0] height_reg = SENSOR_HEIGHT_RST;

  // Stimulus and scoreboard
  ev_t    pending_events[$];
  ev_t    passed_events[$];
  ev_t    offer;
  ev_t    got;
  ev_t    want;
  longint gen_now = 20000;
  int     gen_col = 0;
  int     gen_row = 0;
  bit     gen_pol = 1'b0;
  int     fail_count = 0;
  int     cyc = 0;
  int     in_count = 0;
  bit     in_taken = 1'b0;
  int     hold_left = 0;
  int     holds_done = 0;
  logic   quiet;

  event_neighbour_filter DUT (
    .clk       (clk),
    .rst       (rst),
    .s_tvalid  (s_tvalid),
    .s_tready  (s_tready),
    .s_tdata   (s_tdata),
    .s_tuser   (s_tuser),
    .m_tvalid  (m_tvalid),
    .m_tready  (m_tready),
    .m_tdata   (m_tdata),
    .m_tuser   (m_tuser),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  always #6 clk = ~clk;

  // Periodic stretch with no random gaps or stalls on either stream
  assign quiet = (cyc % 16384) >= 12288;

  task automatic report_mismatch(input string msg);
    if (fail_count < 40) $display("ERROR at %0t: %s", $time, msg);
    fail_count++;
  endtask

  // Model of one accepted event: checks the neighbourhood, then updates the store
  task automatic filter_event(input ev_t e);
    int unsigned cols_used, rows_used, c, r, c0, c1, r0, r1, here, k;
    longint best, base, age, win_l;
    cols_used = (width_reg > MAX_WIDTH_DEF) ? MAX_WIDTH_DEF : width_reg;
    rows_used = (height_reg > MAX_HEIGHT_DEF) ? MAX_HEIGHT_DEF : height_reg;
    c = e.col;
    r = e.row;
    win_l = win_reg;
    // outside the sensor: no state change
    if (c >= cols_used || r >= rows_used) return;
    here = r * MAX_WIDTH_DEF + c;
    // a repeat of the previous event is dropped but still stored
    if (e.col != last_col || e.row != last_row || e.pol != last_pol) begin
      c0 = (c > 0) ? c - 1 : 0;
      c1 = (c + 1 < cols_used) ? c + 1 : c;
      r0 = (r > 0) ? r - 1 : 0;
      r1 = (r + 1 < rows_used) ? r + 1 : r;
      best = 64'sh7FFF_FFFF_FFFF_FFFF;
      for (int unsigned i = r0; i <= r1; i++) begin
        for (int unsigned j = c0; j <= c1; j++) begin
          k = i * MAX_WIDTH_DEF + j;
          // own pixel and unwritten pixels count as never seen
          if (k != here && seen_mem[k]) base = stamp_mem[k];
          else base = -win_l;
          age = longint'(e.stamp) - base;
          if (age < best) best = age;
        end
      end
      if (best <= win_l) passed_events = {passed_events, e};
    end
    stamp_mem[here] = e.stamp;
    seen_mem[here] = 1'b1;
    last_col = e.col;
    last_row = e.row;
    last_pol = e.pol;
  endtask

  task automatic push_event(input int unsigned c, input int unsigned r,
                            input logic [STAMP_W-1:0] t, input bit p);
    ev_t e;
    e.col = COORD_W'(c);
    e.row = COORD_W'(r);
    e.stamp = t;
    e.pol = p;
    pending_events = {pending_events, e};
  endtask

  task automatic write_reg(input cfg_reg_t idx, input logic [CFG_DATA_W-1:0] val);
    @(negedge clk);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    @(negedge clk);
    cfg_we <= 1'b0;
    case (idx)
      REG_WINDOW:        win_reg = val;
      REG_SENSOR_WIDTH:  width_reg = val[SIZE_REG_W-1:0];
      REG_SENSOR_HEIGHT: height_reg = val[SIZE_REG_W-1:0];
      default: ;  // unused index is ignored by the block
    endcase
  endtask

  // Wait until all events are taken and all passed events have arrived
  task automatic wait_quiet();
    do @(negedge clk);
    while (pending_events.size() != 0 || s_tvalid || passed_events.size() != 0);
    repeat (SETTLE_CYCLES) @(negedge clk);
  endtask

  // Random events: mostly local activity around a moving spot, plus noise
  task automatic gen_burst(input int n);
    int unsigned cols_used, rows_used, kind, cnt;
    longint span, dt;
    ev_t e;
    cols_used = (width_reg > MAX_WIDTH_DEF) ? MAX_WIDTH_DEF : width_reg;
    rows_used = (height_reg > MAX_HEIGHT_DEF) ? MAX_HEIGHT_DEF : height_reg;
    span = (win_reg > 4000) ? 4000 : win_reg;
    cnt = 0;
    while (cnt < n) begin
      kind = $urandom_range(99);
      if (kind < 75) begin
        // neighbourhood activity; some of it with time running backwards
        if ($urandom_range(9) == 0) begin
          gen_col = $urandom_range(cols_used - 1);
          gen_row = $urandom_range(rows_used - 1);
        end else if (kind < 55 || kind >= 65) begin
          gen_col = gen_col + int'($urandom_range(2)) - 1;
          gen_row = gen_row + int'($urandom_range(2)) - 1;
          gen_pol = 1'($urandom_range(1));
        end
        if (gen_col < 0) gen_col = 0;
        if (gen_row < 0) gen_row = 0;
        if (gen_col >= int'(cols_used)) gen_col = cols_used - 1;
        if (gen_row >= int'(rows_used)) gen_row = rows_used - 1;
        if (kind >= 65) dt = -longint'($urandom_range(span));
        else if ($urandom_range(3) == 0) dt = $urandom_range(2 * span);
        else dt = $urandom_range(span / 2);
        gen_now = (gen_now + dt) & 64'h7FFF_FFFF;
        e.col = COORD_W'(gen_col);
        e.row = COORD_W'(gen_row);
        e.stamp = STAMP_W'(gen_now);
        e.pol = gen_pol;
      end else if (kind < 88) begin
        // scattered event somewhere on the sensor
        gen_now = (gen_now + $urandom_range(span)) & 64'h7FFF_FFFF;
        e.col = COORD_W'($urandom_range(cols_used - 1));
        e.row = COORD_W'($urandom_range(rows_used - 1));
        e.stamp = STAMP_W'(gen_now);
        e.pol = 1'($urandom_range(1));
      end else begin
        // noise over the full field ranges
        e.col = COORD_W'($urandom_range(255));
        e.row = COORD_W'($urandom_range(255));
        e.stamp = STAMP_W'($urandom() & STAMP_MAX);
        e.pol = 1'($urandom_range(1));
      end
      if (e.col < cols_used && e.row < rows_used) cnt++;
      pending_events = {pending_events, e};
    end
  endtask

  // Input driver: offers the next pending event once the current one is taken
  always @(negedge clk) begin
    if (!s_tvalid || in_taken) begin
      if (!rst && pending_events.size() != 0 && (quiet || $urandom_range(99) >= 8)) begin
        offer = pending_events.pop_front();
        s_tdata <= {{(TDATA_W - STAMP_LSB - STAMP_W){1'b0}}, offer.stamp, offer.row,
                    offer.col};
        s_tuser <= offer.pol;
        s_tvalid <= 1'b1;
      end else begin
        s_tvalid <= 1'b0;
      end
    end
  end

  // Output ready: random stalls, plus long hold-offs that back up the input
  always @(negedge clk) begin
    if (hold_left > 0) begin
      m_tready <= 1'b0;
      hold_left <= hold_left - 1;
    end else if (holds_done < 2 && in_count >= (holds_done == 0 ? 400 : 1100)) begin
      m_tready <= 1'b0;
      hold_left <= 500;
      holds_done <= holds_done + 1;
    end else begin
      m_tready <= quiet || ($urandom_range(99) >= 8);
    end
  end

  // Monitor: check results first, then model the event taken at this edge
  always @(posedge clk) begin
    cyc <= cyc + 1;
    in_taken <= s_tvalid && s_tready;
    if (!rst) begin
      if (m_tvalid && m_tready) begin
        got.col = m_tdata[COL_LSB +: COORD_W];
        got.row = m_tdata[ROW_LSB +: COORD_W];
        got.stamp = m_tdata[STAMP_LSB +: STAMP_W];
        got.pol = m_tuser;
        if (passed_events.size() == 0) begin
          report_mismatch($sformatf("unexpected event col %0d row %0d stamp %0d pol %0b",
                                    got.col, got.row, got.stamp, got.pol));
        end else begin
          want = passed_events.pop_front();
          if (got.col !== want.col)
            report_mismatch($sformatf("out_col %0d, want %0d", got.col, want.col));
          if (got.row !== want.row)
            report_mismatch($sformatf("out_row %0d, want %0d", got.row, want.row));
          if (got.stamp !== want.stamp)
            report_mismatch($sformatf("out_stamp %0d, want %0d", got.stamp, want.stamp));
          if (got.pol !== want.pol)
            report_mismatch($sformatf("out_polarity %0b, want %0b", got.pol, want.pol));
        end
      end
      if (s_tvalid && s_tready) begin
        filter_event(ev_t'{col: s_tdata[COL_LSB +: COORD_W],
                           row: s_tdata[ROW_LSB +: COORD_W],
                           stamp: s_tdata[STAMP_LSB +: STAMP_W],
                           pol: s_tuser});
        in_count <= in_count + 1;
      end
    end
  end

  // Run limit
  initial begin
    #(1_000_000 * 12);
    $display("TEST FAILED");
    $finish;
  end

  // Test sequence
  initial begin
    repeat (3) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // Reset settings: repeats, edges, outside events, negative age, own pixel
    push_event(0, 0, 0, 0);              // matches the reset previous event
    push_event(1, 0, 100, 0);            // valid neighbour close in time
    push_event(1, 0, 200, 0);            // repeat
    push_event(239, 179, 300, 1);        // bottom-right corner, nothing around
    push_event(238, 178, 5300, 0);       // age equal to the window
    push_event(237, 177, 10301, 1);      // age one over the window
    push_event(240, 0, 500, 1);          // column outside
    push_event(0, 180, 500, 0);          // row outside
    push_event(255, 255, STAMP_MAX, 1);  // both outside
    push_event(5, 5, 50, 0);
    push_event(5, 5, 60, 1);             // own pixel counts as never seen
    push_event(6, 5, 40, 0);             // neighbour later than the event
    push_event(100, 100, 0, 1);          // stamp zero against empty neighbours
    push_event(50, 50, STAMP_MAX, 0);
    push_event(51, 51, STAMP_MAX, 1);    // age zero at the largest stamp
    push_event(0, 0, 150, 1);            // top-left corner
    push_event(239, 0, 400, 0);          // top-right corner
    wait_quiet();

    // Zero window, oversized sensor registers
    write_reg(REG_WINDOW, 0);
    write_reg(REG_SENSOR_WIDTH, 511);
    write_reg(REG_SENSOR_HEIGHT, 300);
    push_event(255, 255, 1000, 1);
    push_event(254, 254, 1000, 0);
    push_event(253, 253, 1001, 1);
    gen_burst(250);
    wait_quiet();

    // Largest window on a single pixel
    write_reg(REG_WINDOW, STAMP_MAX);
    write_reg(REG_SENSOR_WIDTH, 1);
    write_reg(REG_SENSOR_HEIGHT, 1);
    push_event(0, 0, 0, 1);
    push_event(0, 0, 5, 0);
    push_event(1, 0, 5, 1);
    push_event(0, 1, 5, 1);
    gen_burst(60);
    wait_quiet();

    // Zero-sized sensor in either direction, and the unused register index
    write_reg(REG_WINDOW, 1000);
    write_reg(REG_SENSOR_WIDTH, 0);
    write_reg(REG_SENSOR_HEIGHT, 4);
    write_reg(REG_UNUSED, CFG_DATA_W'($urandom()));
    push_event(0, 0, 100, 1);
    push_event(3, 2, 110, 0);
    wait_quiet();
    write_reg(REG_SENSOR_WIDTH, 4);
    write_reg(REG_SENSOR_HEIGHT, 0);
    push_event(0, 0, 120, 0);
    push_event(2, 3, 130, 1);
    wait_quiet();

    // Random phases over a range of settings
    write_reg(REG_WINDOW, 300);
    write_reg(REG_SENSOR_WIDTH, 8);
    write_reg(REG_SENSOR_HEIGHT, 6);
    gen_burst(300);
    wait_quiet();

    write_reg(REG_WINDOW, CFG_DATA_W'($urandom_range(20000, 1)));
    write_reg(REG_SENSOR_WIDTH, 16);
    write_reg(REG_SENSOR_HEIGHT, 16);
    gen_burst(300);
    wait_quiet();

    write_reg(REG_WINDOW, 5000);
    write_reg(REG_SENSOR_WIDTH, 256);
    write_reg(REG_SENSOR_HEIGHT, 256);
    gen_burst(300);
    wait_quiet();

    write_reg(REG_WINDOW, 50);
    write_reg(REG_SENSOR_WIDTH, 3);
    write_reg(REG_SENSOR_HEIGHT, 200);
    gen_burst(200);
    wait_quiet();

    write_reg(REG_WINDOW, CFG_DATA_W'($urandom() & STAMP_MAX));
    write_reg(REG_SENSOR_WIDTH, 40);
    write_reg(REG_SENSOR_HEIGHT, 40);
    gen_burst(200);
    wait_quiet();

    if (fail_count == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule
